// ----- rtl/core/crd_pkg.sv -----
package crd_pkg;

   // record layout, counted from the first byte after the version byte
   localparam logic [6:0] FixedLast = 7'd105;
   localparam logic [6:0] CtlenAt   = 7'd20;
   localparam logic [6:0] CtlenEnd  = 7'd24;
   localparam logic [6:0] HashAt    = 7'd72;
   localparam logic [6:0] HashEnd   = 7'd104;
   localparam logic [6:0] SiglenAt  = 7'd104;
   localparam logic [6:0] SiglenEnd = 7'd106;
   localparam logic [6:0] MagicLast = 7'd3;
   localparam logic [7:0] RecVersion = 8'd2;
   localparam logic [1:0] LastWord  = 2'd3;

   typedef enum logic [3:0] {
      PH_MAGIC   = 4'b0001,
      PH_VERSION = 4'b0010,
      PH_FIXED   = 4'b0100,
      PH_SKIP    = 4'b1000
   } phase_type;

   typedef logic [3:0][63:0] hash_type;

   // what the log end hands to the output stage
   typedef struct packed {
      hash_type    hash;
      logic        halted;
      logic [31:0] count;
   } snap_type;

   function automatic logic [7:0] magic_byte(input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0:    b = 8'h48;  // 'H'
         2'd1:    b = 8'h45;  // 'E'
         2'd2:    b = 8'h53;  // 'S'
         default: b = 8'h32;  // '2'
      endcase
      return b;
   endfunction

endpackage

// ----- rtl/core/chained_record_deframer.sv -----
// chained record deframer: takes a chained log one byte per req beat, checks each record's
// magic and version, captures the 32-byte record hash from the fixed part and skips the
// signature and ciphertext bytes that follow. a byte beat is taken every cycle with no
// gaps; the byte is folded into the parse state in the same cycle it is accepted. a beat
// with req_tlast set ends the log (its byte, if req_tuser marks one present, is parsed
// first) and produces four rsp beats carrying the latest hash, word 0 first, big-endian
// bytes. the four words leave one per cycle, while rsp_tready is high, from a shift register
// that holds a snapshot of the finished log, so byte beats of the next log keep flowing while
// they drain; only a further end beat waits (req_tready low while req_tlast is set) until the
// last word has gone. the parser is back at its reset state right after the end beat, so the
// next log may start at once.
module chained_record_deframer (
   input  logic         clock,
   input  logic         reset,
   // request stream
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] data_byte
   input  logic         req_tuser,   // [0] byte_present
   input  logic         req_tlast,   // end_of_log
   // response stream
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,   // [63:0] hash_word, [64] stopped_early,
                                     // [96:65] record_count, [103:97] zero
   output logic [1:0]   rsp_tuser,   // [1:0] word_index
   output logic         rsp_tlast    // last_word
);
   import crd_pkg::*;

   logic        req_take;
   logic        rsp_take;
   logic        end_take;
   snap_type    snap;

   // output stage: snapshot of the finished log, drained one word per beat
   logic        busy_ff,   busy_in;
   logic [1:0]  idx_ff,    idx_in;
   hash_type    words_ff,  words_in;
   logic        halted_ff, halted_in;
   logic [31:0] count_ff,  count_in;

   // byte beats pass while draining, an end beat needs the output stage free
   assign req_tready = !busy_ff || !req_tlast;
   assign req_take   = req_tvalid && req_tready;
   assign end_take   = req_take && req_tlast;
   assign rsp_take   = rsp_tvalid && rsp_tready;

   crd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .take      (req_take),
      .present   (req_tuser),
      .last_item (req_tlast),
      .data_byte (req_tdata),
      .snap      (snap)
   );

   always_comb begin
      busy_in   = busy_ff;
      idx_in    = idx_ff;
      words_in  = words_ff;
      halted_in = halted_ff;
      count_in  = count_ff;
      if (end_take) begin
         // log ended: latch hash and status, start with word 0
         busy_in   = 1'b1;
         idx_in    = '0;
         words_in  = snap.hash;
         halted_in = snap.halted;
         count_in  = snap.count;
      end else if (rsp_take) begin
         if (idx_ff == LastWord) begin
            busy_in = 1'b0;
         end else begin
            idx_in   = idx_ff + 2'd1;
            words_in = {64'd0, words_ff[3:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      words_ff  <= words_in;
      halted_ff <= halted_in;
      count_ff  <= count_in;
   end

   assign rsp_tvalid = busy_ff;
   assign rsp_tdata  = {7'd0, count_ff, halted_ff, words_ff[0]};
   assign rsp_tuser  = idx_ff;
   assign rsp_tlast  = (idx_ff == LastWord);

   // no new end of log while a hash is still draining
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !end_take)
      else $error("end of log taken while response pending");

   // end of log starts the drain at word 0
   assert property (@(posedge clock) disable iff (reset)
      end_take |=> rsp_tvalid && rsp_tuser == 2'd0)
      else $error("end of log did not start hash output at word 0");

   // words step by one per beat until the last
   assert property (@(posedge clock) disable iff (reset)
      rsp_take && !rsp_tlast |=> rsp_tvalid && rsp_tuser == $past(rsp_tuser) + 2'd1)
      else $error("hash word index did not advance");

   // status fields hold over all four words
   assert property (@(posedge clock) disable iff (reset)
      rsp_take && !rsp_tlast |=> $stable(rsp_tdata[96:64]))
      else $error("status changed within one hash output");

   // last word ends the drain
   assert property (@(posedge clock) disable iff (reset)
      rsp_take && rsp_tlast |=> !rsp_tvalid)
      else $error("response still valid after last word");

endmodule

// ----- rtl/core/crd_parser.sv -----
module crd_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  logic              present,
   input  logic              last_item,
   input  logic [7:0]        data_byte,
   output crd_pkg::snap_type snap
);
   import crd_pkg::*;

   phase_type   phase_ff,   phase_in;
   logic [6:0]  pos_ff,     pos_in;
   logic [31:0] ctlen_ff,   ctlen_in;
   logic [15:0] siglen_ff,  siglen_in;
   logic [32:0] skip_ff,    skip_in;
   hash_type    pending_ff, pending_in;
   hash_type    latest_ff,  latest_in;
   logic        halted_ff,  halted_in;
   logic        bad_ff,     bad_in;
   logic [31:0] count_ff,   count_in;
   logic [6:0]  hash_off;
   logic [32:0] skip_dec;

   assign hash_off = pos_ff - HashAt;
   assign skip_dec = skip_ff - 33'd1;

   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      ctlen_in   = ctlen_ff;
      siglen_in  = siglen_ff;
      skip_in    = skip_ff;
      pending_in = pending_ff;
      latest_in  = latest_ff;
      halted_in  = halted_ff;
      bad_in     = bad_ff;
      count_in   = count_ff;
      if (present && !halted_ff) begin
         case (phase_ff)
            PH_MAGIC: begin
               bad_in = bad_ff | (data_byte != magic_byte(pos_ff[1:0]));
               pos_in = pos_ff + 7'd1;
               if (pos_ff == MagicLast) begin
                  pos_in = '0;
                  if (bad_in) begin
                     halted_in = 1'b1;
                  end else begin
                     phase_in = PH_VERSION;
                  end
                  bad_in = 1'b0;
               end
            end
            PH_VERSION: begin
               if (data_byte != RecVersion) begin
                  halted_in = 1'b1;
               end else begin
                  phase_in = PH_FIXED;
                  pos_in   = '0;
               end
            end
            PH_FIXED: begin
               if (pos_ff >= CtlenAt && pos_ff < CtlenEnd) begin
                  ctlen_in = {ctlen_ff[23:0], data_byte};
               end
               if (pos_ff >= HashAt && pos_ff < HashEnd) begin
                  pending_in[hash_off[4:3]] = {pending_ff[hash_off[4:3]][55:0], data_byte};
               end
               if (pos_ff >= SiglenAt && pos_ff < SiglenEnd) begin
                  siglen_in = {siglen_ff[7:0], data_byte};
               end
               pos_in = pos_ff + 7'd1;
               if (pos_ff == FixedLast) begin
                  // fixed part complete: commit the hash, then skip payload
                  latest_in = pending_in;
                  if (count_ff != '1) begin
                     count_in = count_ff + 32'd1;
                  end
                  skip_in  = {1'b0, ctlen_in} + {17'd0, siglen_in};
                  pos_in   = '0;
                  phase_in = (skip_in != '0) ? PH_SKIP : PH_MAGIC;
               end
            end
            PH_SKIP: begin
               skip_in = skip_dec;
               if (skip_dec == '0) begin
                  phase_in = PH_MAGIC;
                  pos_in   = '0;
               end
            end
            default: begin
               phase_in = PH_MAGIC;
            end
         endcase
      end
   end

   assign snap.hash   = latest_in;
   assign snap.halted = halted_in;
   assign snap.count  = count_in;

   always_ff @(posedge clock) begin
      if (reset || (take && last_item)) begin
         phase_ff   <= PH_MAGIC;
         pos_ff     <= '0;
         ctlen_ff   <= '0;
         siglen_ff  <= '0;
         skip_ff    <= '0;
         pending_ff <= '0;
         latest_ff  <= '0;
         halted_ff  <= 1'b0;
         bad_ff     <= 1'b0;
         count_ff   <= '0;
      end else if (take) begin
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         ctlen_ff   <= ctlen_in;
         siglen_ff  <= siglen_in;
         skip_ff    <= skip_in;
         pending_ff <= pending_in;
         latest_ff  <= latest_in;
         halted_ff  <= halted_in;
         bad_ff     <= bad_in;
         count_ff   <= count_in;
      end
   end

endmodule

// ----- tb/sv/chained_record_deframer_checker.sv -----
module chained_record_deframer_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [7:0]   req_tdata,       // [7:0] data_byte
   input  logic         req_tuser,       // [0] byte_present
   input  logic         req_tlast,       // end_of_log
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [103:0] rsp_tdata,       // [63:0] hash_word, [64] stopped_early,
                                         // [96:65] record_count, [103:97] zero
   input  logic [1:0]   rsp_tuser,       // [1:0] word_index
   input  logic         rsp_tlast,       // last_word
   output int           fail_count,
   output int           words_due,
   output int           words_checked,
   output int           logs_closed,
   output int           records_parsed
);
   import crd_pkg::*;

   localparam logic [31:0] MagicText = "HES2";

   typedef struct packed {
      logic [63:0] word;
      logic [1:0]  index;
      logic        last;
      logic        stopped;
      logic [31:0] count;
   } hash_beat_type;

   hash_beat_type hash_words_due[$];

   // parser mirror
   phase_type   parse_phase;
   logic [6:0]  byte_pos;
   logic [31:0] ct_len;
   logic [15:0] sig_len;
   logic [32:0] skip_left;
   hash_type    hash_building;
   hash_type    hash_latest;
   logic        parse_halted;
   logic        magic_off;
   logic [31:0] record_total;

   int fails;
   int checked;
   int logs;
   int records;

   task automatic clear_parser();
      parse_phase   = PH_MAGIC;
      byte_pos      = '0;
      ct_len        = '0;
      sig_len       = '0;
      skip_left     = '0;
      hash_building = '0;
      hash_latest   = '0;
      parse_halted  = 1'b0;
      magic_off     = 1'b0;
      record_total  = '0;
   endtask

   task automatic fold_log_byte(input logic [7:0] b);
      int sel;
      int w;
      if (!parse_halted) begin
         case (parse_phase)
            PH_MAGIC: begin
               sel = 3 - byte_pos[1:0];
               if (b != MagicText[8*sel +: 8])
                  magic_off = 1'b1;
               if (byte_pos[1:0] == MagicLast[1:0]) begin
                  byte_pos = '0;
                  if (magic_off)
                     parse_halted = 1'b1;
                  else
                     parse_phase = PH_VERSION;
                  magic_off = 1'b0;
               end else begin
                  byte_pos = byte_pos + 7'd1;
               end
            end
            PH_VERSION: begin
               if (b != RecVersion) begin
                  parse_halted = 1'b1;
               end else begin
                  parse_phase = PH_FIXED;
                  byte_pos    = '0;
               end
            end
            PH_FIXED: begin
               if (byte_pos >= CtlenAt && byte_pos < CtlenEnd)
                  ct_len = {ct_len[23:0], b};
               if (byte_pos >= HashAt && byte_pos < HashEnd) begin
                  w = (byte_pos - HashAt) >> 3;
                  hash_building[w] = {hash_building[w][55:0], b};
               end
               if (byte_pos >= SiglenAt && byte_pos < SiglenEnd)
                  sig_len = {sig_len[7:0], b};
               if (byte_pos == FixedLast) begin
                  // fixed part complete: the record counts from here on
                  hash_latest = hash_building;
                  if (record_total != '1)
                     record_total = record_total + 32'd1;
                  records++;
                  skip_left   = {1'b0, ct_len} + sig_len;
                  byte_pos    = '0;
                  parse_phase = (skip_left != '0) ? PH_SKIP : PH_MAGIC;
               end else begin
                  byte_pos = byte_pos + 7'd1;
               end
            end
            default: begin
               if (skip_left != '0)
                  skip_left = skip_left - 33'd1;
               if (skip_left == '0) begin
                  parse_phase = PH_MAGIC;
                  byte_pos    = '0;
               end
            end
         endcase
      end
   endtask

   task automatic close_log();
      hash_beat_type hb;
      logic [2:0]    k;
      for (k = 3'd0; k < 3'd4; k++) begin
         hb.word    = hash_latest[k[1:0]];
         hb.index   = k[1:0];
         hb.last    = (k[1:0] == LastWord);
         hb.stopped = parse_halted;
         hb.count   = record_total;
         hash_words_due.insert(hash_words_due.size(), hb);
      end
      logs++;
      clear_parser();
   endtask

   always @(posedge clock) begin
      hash_beat_type want;
      if (reset) begin
         clear_parser();
         hash_words_due.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            // a byte on the end beat is parsed before the hash goes out
            if (req_tuser)
               fold_log_byte(req_tdata);
            if (req_tlast)
               close_log();
         end
         if (rsp_tvalid && rsp_tready) begin
            checked++;
            if (hash_words_due.size() == 0) begin
               fails++;
               if (fails <= 10)
                  $display("unexpected hash word %h idx %0d with nothing due",
                           rsp_tdata[63:0], rsp_tuser);
            end else begin
               want = hash_words_due.pop_front();
               if (rsp_tdata[63:0] !== want.word || rsp_tuser !== want.index ||
                   rsp_tlast !== want.last || rsp_tdata[64] !== want.stopped ||
                   rsp_tdata[96:65] !== want.count) begin
                  fails++;
                  if (fails <= 10)
                     $display({"hash word mismatch: expected %h idx %0d last %b stop %b ",
                               "count %0d, got %h idx %0d last %b stop %b count %0d"},
                              want.word, want.index, want.last, want.stopped, want.count,
                              rsp_tdata[63:0], rsp_tuser, rsp_tlast, rsp_tdata[64],
                              rsp_tdata[96:65]);
               end
            end
         end
      end
      fail_count     <= fails;
      words_due      <= hash_words_due.size();
      words_checked  <= checked;
      logs_closed    <= logs;
      records_parsed <= records;
   end

endmodule

// ----- tb/sv/chained_record_deframer_tb.sv -----
module chained_record_deframer_tb;

   import crd_pkg::*;

   // pacing of both sides, stepped every 24 beats
   typedef enum int {
      PACE_FREE,
      PACE_SENDER_IDLE,
      PACE_RECEIVER_STALL,
      PACE_BOTH
   } pace_type;

   // how the fixed bytes of a record are filled
   typedef enum int {
      FILL_RANDOM,
      FILL_ZERO,
      FILL_ONES
   } fill_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = 8'h00;   // [7:0] data_byte
   logic         req_tuser = 1'b0;    // [0] byte_present
   logic         req_tlast = 1'b0;    // end_of_log
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b1;
   logic [103:0] rsp_tdata;           // [63:0] hash_word, [64] stopped_early,
                                      // [96:65] record_count, [103:97] zero
   logic [1:0]   rsp_tuser;           // [1:0] word_index
   logic         rsp_tlast;           // last_word

   int fail_count;
   int words_due;
   int words_checked;
   int logs_closed;
   int records_parsed;

   // stimulus bookkeeping
   logic [7:0] log_bytes[$];
   int         idle_pct  = 0;
   int         stall_pct = 0;
   int         logs_sent = 0;
   int         bytes_sent = 0;
   int         beats_sent = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   chained_record_deframer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   chained_record_deframer_checker u_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .fail_count     (fail_count),
      .words_due      (words_due),
      .words_checked  (words_checked),
      .logs_closed    (logs_closed),
      .records_parsed (records_parsed)
   );

   // receiver side: random back-pressure on the hash words
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // one req beat, with random sender gaps ahead of it; pacing steps every 24 beats
   task automatic drive_beat(input logic [7:0] b, input logic present, input logic last);
      case (pace_type'((beats_sent / 24) % 4))
         PACE_FREE:           begin idle_pct = 0;  stall_pct = 0;  end
         PACE_SENDER_IDLE:    begin idle_pct = 55; stall_pct = 0;  end
         PACE_RECEIVER_STALL: begin idle_pct = 0;  stall_pct = 55; end
         default:             begin idle_pct = 6;  stall_pct = 6;  end
      endcase
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= present;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      beats_sent++;
   endtask

   // sender goes quiet until every hash word already due has come out
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (words_due != 0) @(posedge clock);
   endtask

   // magic, version, 106 fixed bytes with both lengths in place, then some payload
   task automatic put_record(input logic [31:0] ct, input logic [15:0] sig, input int pay,
                             input logic [7:0] ver, input bit magic_ok, input fill_type fill);
      logic [31:0] magic;
      logic [7:0]  b;
      int          spoil;
      magic = "HES2";
      if (!magic_ok) begin
         spoil = $urandom_range(3);
         magic[8*spoil +: 8] ^= 8'($urandom_range(255, 1));
      end
      for (int i = 3; i >= 0; i--)
         log_bytes.insert(log_bytes.size(), magic[8*i +: 8]);
      log_bytes.insert(log_bytes.size(), ver);
      for (int p = 0; p <= FixedLast; p++) begin
         case (fill)
            FILL_ZERO: b = 8'h00;
            FILL_ONES: b = 8'hFF;
            default:   b = 8'($urandom);
         endcase
         // big-endian length fields
         if (p >= CtlenAt && p < CtlenEnd)
            b = ct[8*(CtlenEnd - 1 - p) +: 8];
         if (p >= SiglenAt && p < SiglenEnd)
            b = sig[8*(SiglenEnd - 1 - p) +: 8];
         log_bytes.insert(log_bytes.size(), b);
      end
      for (int i = 0; i < pay; i++)
         log_bytes.insert(log_bytes.size(), 8'($urandom));
   endtask

   // sends the collected bytes as one log; the end rides on the last byte or
   // on a beat of its own with no byte
   task automatic send_log(input bit end_on_byte);
      int n;
      n = log_bytes.size();
      if (logs_sent % 5 == 4)
         drain_results();
      for (int i = 0; i < n; i++) begin
         // now and then an empty beat that the block must ignore
         if ($urandom_range(39) == 0)
            drive_beat(8'($urandom), 1'b0, 1'b0);
         drive_beat(log_bytes[i], 1'b1, end_on_byte && i == n - 1);
      end
      if (!end_on_byte || n == 0)
         drive_beat(8'($urandom), 1'b0, 1'b1);
      bytes_sent += n;
      logs_sent++;
      log_bytes.delete();
   endtask

   initial begin : stimulus
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // empty log, end beat with no byte
      send_log(1'b0);
      // a lone noise byte on the end beat
      log_bytes.insert(log_bytes.size(), 8'($urandom));
      send_log(1'b1);
      // log ends inside the magic: clean end, nothing counted
      log_bytes.insert(log_bytes.size(), 8'h48);
      log_bytes.insert(log_bytes.size(), 8'h45);
      send_log(1'b0);
      // bad magic, the bytes after it are ignored
      put_record(32'd0, 16'd0, 0, RecVersion, 1'b0, FILL_ZERO);
      repeat (105) void'(log_bytes.pop_back());
      send_log(1'b1);
      // bad version on the end beat
      put_record(32'd0, 16'd0, 0, 8'hFF, 1'b1, FILL_RANDOM);
      repeat (106) void'(log_bytes.pop_back());
      send_log(1'b1);
      // record with no payload, its last fixed byte on the end beat
      put_record(32'd0, 16'd0, 0, RecVersion, 1'b1, FILL_RANDOM);
      send_log(1'b1);
      // payload fully skipped, then a record cut inside its fixed part: first hash kept
      put_record(32'd1, 16'd1, 2, RecVersion, 1'b1, FILL_RANDOM);
      put_record(32'd0, 16'd0, 0, RecVersion, 1'b1, FILL_RANDOM);
      repeat (96) void'(log_bytes.pop_back());
      send_log(1'b0);
      // largest lengths, all-ones bytes, payload cut short by the end
      put_record(32'hFFFF_FFFF, 16'hFFFF, 3, RecVersion, 1'b1, FILL_ONES);
      send_log(1'b1);

      // wait out the last hash words, then a few extra cycles for strays
      drain_results();
      repeat (20) @(posedge clock);

      $display("covered %0d logs, %0d log bytes in %0d beats, %0d records parsed",
               logs_sent, bytes_sent, beats_sent, records_parsed);
      $display("%0d hash words compared, %0d mismatches", words_checked, fail_count);
      if (fail_count == 0 && words_due == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #2000000;
      $display("FAIL");
      $finish;
   end

endmodule
